@@ rtl/quadratic_root_solver_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic root solver
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define QRS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("quadratic_root_solver: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define QRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("quadratic_root_solver: next-cycle check failed");
`else
`define QRS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define QRS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, status codes, register indexes and sideband types of the solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEFF_WIDTH     = 24;
  localparam int COEFF_FRAC_BITS = 12;
  localparam int ROOT_WIDTH      = 32;
  localparam int GUARD_BITS      = 4;

  // magnitudes, products, discriminant
  localparam int MAG_W  = COEFF_WIDTH;
  localparam int PROD_W = 2 * MAG_W;
  localparam int DISC_W = PROD_W + 1;

  // square root of D * 4^GUARD_BITS, input padded to an even width
  localparam int SQ_IN_W   = ((DISC_W + 2 * GUARD_BITS + 1) / 2) * 2;
  localparam int SQ_ROOT_W = SQ_IN_W / 2;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;

  // numerators -b*2^G +/- sqrt
  localparam int N_W    = SQ_ROOT_W + 2;
  localparam int NMAG_W = SQ_ROOT_W + 1;

  // divider operands (numerator has one bit of headroom for rounding)
  localparam int DIV_NUM_W = NMAG_W + COEFF_FRAC_BITS + 1;
  localparam int DIV_DEN_W = MAG_W + 1 + GUARD_BITS;

  // configuration
  localparam int CTOL_W     = 23;
  localparam int DTOL_W     = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_TOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISC_TOL  = 1'b1;

  // status codes
  localparam int STATUS_W = 3;
  localparam logic [STATUS_W-1:0] ST_NONE   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LINEAR = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DOUBLE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TWO    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEGEN  = 3'd4;

  // magnitude of the most negative root
  localparam logic [DIV_NUM_W-1:0] ROOT_MAG_LIMIT = DIV_NUM_W'(64'd1 << (ROOT_WIDTH - 1));

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                sa;
    logic                sb;
    logic                sc;
    logic [MAG_W-1:0]    am;
    logic [MAG_W-1:0]    bm;
    logic [MAG_W-1:0]    cm;
  } sq_side_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                neg;
  } div_tag_t;

endpackage

@@ rtl/qrs_if.sv @@
// ----------------------------------------------------------------------------
// qrs channel interfaces
// Coefficient, result and configuration channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qrs_coef_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [qrs_pkg::COEFF_WIDTH-1:0]   coef_a;
  logic signed [qrs_pkg::COEFF_WIDTH-1:0]   coef_b;
  logic signed [qrs_pkg::COEFF_WIDTH-1:0]   coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_result_if;
  logic                                     valid;
  logic                                     ready;
  logic        [qrs_pkg::STATUS_W-1:0]      root_status;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0]    first_root;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0]    second_root;
  logic                                     saturated;

  modport source (output valid, root_status, first_root, second_root, saturated,
                  input ready);
  modport sink   (input valid, root_status, first_root, second_root, saturated,
                  output ready);
endinterface

interface qrs_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [qrs_pkg::CFG_IDX_W-1:0]       index;
  logic [qrs_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/qrs_front.sv @@
// ----------------------------------------------------------------------------
// qrs_front
// Four stages: magnitudes and zero tests, products, discriminant, status.
// ----------------------------------------------------------------------------
module qrs_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic signed [qrs_pkg::COEFF_WIDTH-1:0]  coef_a,
  input  logic signed [qrs_pkg::COEFF_WIDTH-1:0]  coef_b,
  input  logic signed [qrs_pkg::COEFF_WIDTH-1:0]  coef_c,
  input  logic [qrs_pkg::CTOL_W-1:0]              coeff_tol,
  input  logic [qrs_pkg::DTOL_W-1:0]              disc_tol,
  output logic                                    out_valid,
  output logic [qrs_pkg::SQ_IN_W-1:0]             out_x,
  output qrs_pkg::sq_side_t                       out_side
);

  // stage 1
  logic [qrs_pkg::MAG_W-1:0] am_n, bm_n, cm_n;
  logic                      s1_valid, s1_azero, s1_bzero, s1_sa, s1_sb, s1_sc;
  logic [qrs_pkg::MAG_W-1:0] s1_am, s1_bm, s1_cm;

  always_comb begin
    am_n = coef_a[qrs_pkg::COEFF_WIDTH-1] ? (~$unsigned(coef_a) + 1'b1) : $unsigned(coef_a);
    bm_n = coef_b[qrs_pkg::COEFF_WIDTH-1] ? (~$unsigned(coef_b) + 1'b1) : $unsigned(coef_b);
    cm_n = coef_c[qrs_pkg::COEFF_WIDTH-1] ? (~$unsigned(coef_c) + 1'b1) : $unsigned(coef_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_am    <= am_n;
      s1_bm    <= bm_n;
      s1_cm    <= cm_n;
      s1_sa    <= coef_a[qrs_pkg::COEFF_WIDTH-1];
      s1_sb    <= coef_b[qrs_pkg::COEFF_WIDTH-1];
      s1_sc    <= coef_c[qrs_pkg::COEFF_WIDTH-1];
      s1_azero <= (am_n == '0) || (am_n < qrs_pkg::MAG_W'(coeff_tol));
      s1_bzero <= (bm_n == '0) || (bm_n < qrs_pkg::MAG_W'(coeff_tol));
    end
  end

  // stage 2: b*b and a*c
  logic                       s2_valid, s2_azero, s2_bzero, s2_sa, s2_sb, s2_sc;
  logic [qrs_pkg::MAG_W-1:0]  s2_am, s2_bm, s2_cm;
  logic [qrs_pkg::PROD_W-1:0] s2_bb, s2_ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_bb    <= s1_bm * s1_bm;
      s2_ac    <= s1_am * s1_cm;
      s2_am    <= s1_am;
      s2_bm    <= s1_bm;
      s2_cm    <= s1_cm;
      s2_sa    <= s1_sa;
      s2_sb    <= s1_sb;
      s2_sc    <= s1_sc;
      s2_azero <= s1_azero;
      s2_bzero <= s1_bzero;
    end
  end

  // stage 3: D = b*b - 4ac, sign handled on magnitudes
  logic [qrs_pkg::DISC_W-1:0] ac4, dsum;
  logic [qrs_pkg::DISC_W:0]   dsub;
  logic                       add_case;
  logic                       s3_valid, s3_azero, s3_bzero, s3_sa, s3_sb, s3_sc, s3_dneg;
  logic [qrs_pkg::MAG_W-1:0]  s3_am, s3_bm, s3_cm;
  logic [qrs_pkg::DISC_W-1:0] s3_d;

  always_comb begin
    ac4      = qrs_pkg::DISC_W'(s2_ac) << 2;
    dsum     = qrs_pkg::DISC_W'(s2_bb) + ac4;
    dsub     = {1'b0, qrs_pkg::DISC_W'(s2_bb)} - {1'b0, ac4};
    add_case = (s2_sa != s2_sc) || (s2_cm == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d     <= add_case ? dsum : dsub[qrs_pkg::DISC_W-1:0];
      s3_dneg  <= !add_case && dsub[qrs_pkg::DISC_W];
      s3_am    <= s2_am;
      s3_bm    <= s2_bm;
      s3_cm    <= s2_cm;
      s3_sa    <= s2_sa;
      s3_sb    <= s2_sb;
      s3_sc    <= s2_sc;
      s3_azero <= s2_azero;
      s3_bzero <= s2_bzero;
    end
  end

  // stage 4: classify
  logic [qrs_pkg::STATUS_W-1:0] status_n;
  logic                         s4_valid;
  logic [qrs_pkg::SQ_IN_W-1:0]  s4_x;
  qrs_pkg::sq_side_t            s4_side;

  always_comb begin
    if (s3_azero) begin
      status_n = s3_bzero ? qrs_pkg::ST_DEGEN : qrs_pkg::ST_LINEAR;
    end else if (s3_dneg) begin
      status_n = qrs_pkg::ST_NONE;
    end else if (s3_d < qrs_pkg::DISC_W'(disc_tol)) begin
      status_n = qrs_pkg::ST_DOUBLE;
    end else begin
      status_n = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x           <= qrs_pkg::SQ_IN_W'({s3_d, {(2 * qrs_pkg::GUARD_BITS){1'b0}}});
      s4_side.status <= status_n;
      s4_side.sa     <= s3_sa;
      s4_side.sb     <= s3_sb;
      s4_side.sc     <= s3_sc;
      s4_side.am     <= s3_am;
      s4_side.bm     <= s3_bm;
      s4_side.cm     <= s3_cm;
    end
  end

  assign out_valid = s4_valid;
  assign out_x     = s4_x;
  assign out_side  = s4_side;

endmodule

@@ rtl/qrs_sqrt.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [qrs_pkg::SQ_IN_W-1:0]       in_x,
  input  qrs_pkg::sq_side_t                 in_side,
  output logic                              out_valid,
  output logic [qrs_pkg::SQ_ROOT_W-1:0]     out_root,
  output qrs_pkg::sq_side_t                 out_side
);

  logic                             valid [qrs_pkg::SQ_ROOT_W];
  logic [qrs_pkg::SQ_IN_W-1:0]      xr    [qrs_pkg::SQ_ROOT_W];
  logic [qrs_pkg::SQ_ROOT_W-1:0]    root  [qrs_pkg::SQ_ROOT_W];
  logic [qrs_pkg::SQ_REM_W-1:0]     rem   [qrs_pkg::SQ_ROOT_W];
  qrs_pkg::sq_side_t                side  [qrs_pkg::SQ_ROOT_W];

  for (genvar k = 0; k < qrs_pkg::SQ_ROOT_W; k++) begin : g_stage
    logic                          v_in;
    logic [qrs_pkg::SQ_IN_W-1:0]   x_in;
    logic [qrs_pkg::SQ_ROOT_W-1:0] root_in;
    logic [qrs_pkg::SQ_REM_W-1:0]  rem_in, cur, trial;
    qrs_pkg::sq_side_t             s_in;
    logic                          ge;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_x;
      assign root_in = '0;
      assign rem_in  = '0;
      assign s_in    = in_side;
    end else begin : g_rest
      assign v_in    = valid[k-1];
      assign x_in    = xr[k-1];
      assign root_in = root[k-1];
      assign rem_in  = rem[k-1];
      assign s_in    = side[k-1];
    end

    // bring down the next two bits, try (4*root + 1)
    assign cur   = {rem_in[qrs_pkg::SQ_REM_W-3:0], x_in[qrs_pkg::SQ_IN_W-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[k]   <= x_in << 2;
        root[k] <= {root_in[qrs_pkg::SQ_ROOT_W-2:0], ge};
        rem[k]  <= ge ? (cur - trial) : cur;
        side[k] <= s_in;
      end
    end
  end

  assign out_valid = valid[qrs_pkg::SQ_ROOT_W-1];
  assign out_root  = root[qrs_pkg::SQ_ROOT_W-1];
  assign out_side  = side[qrs_pkg::SQ_ROOT_W-1];

endmodule

@@ rtl/qrs_div.sv @@
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [qrs_pkg::DIV_NUM_W-1:0]     in_num,
  input  logic [qrs_pkg::DIV_DEN_W-1:0]     in_den,
  input  qrs_pkg::div_tag_t                 in_tag,
  output logic                              out_valid,
  output logic [qrs_pkg::DIV_NUM_W-1:0]     out_q,
  output qrs_pkg::div_tag_t                 out_tag
);

  logic                             valid [qrs_pkg::DIV_NUM_W];
  logic [qrs_pkg::DIV_NUM_W-1:0]    num   [qrs_pkg::DIV_NUM_W];
  logic [qrs_pkg::DIV_DEN_W-1:0]    den   [qrs_pkg::DIV_NUM_W];
  logic [qrs_pkg::DIV_DEN_W-1:0]    rem   [qrs_pkg::DIV_NUM_W];
  logic [qrs_pkg::DIV_NUM_W-1:0]    quo   [qrs_pkg::DIV_NUM_W];
  qrs_pkg::div_tag_t                tag   [qrs_pkg::DIV_NUM_W];

  for (genvar k = 0; k < qrs_pkg::DIV_NUM_W; k++) begin : g_stage
    logic                          v_in;
    logic [qrs_pkg::DIV_NUM_W-1:0] num_in, q_in;
    logic [qrs_pkg::DIV_DEN_W-1:0] den_in, rem_in;
    qrs_pkg::div_tag_t             t_in;
    logic [qrs_pkg::DIV_DEN_W:0]   cur, diff;
    logic                          ge;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign num_in = in_num;
      assign den_in = in_den;
      assign rem_in = '0;
      assign q_in   = '0;
      assign t_in   = in_tag;
    end else begin : g_rest
      assign v_in   = valid[k-1];
      assign num_in = num[k-1];
      assign den_in = den[k-1];
      assign rem_in = rem[k-1];
      assign q_in   = quo[k-1];
      assign t_in   = tag[k-1];
    end

    // remainder stays below den, so the shifted value fits one extra bit
    assign cur  = {rem_in, num_in[qrs_pkg::DIV_NUM_W-1]};
    assign diff = cur - {1'b0, den_in};
    assign ge   = (cur >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k] <= num_in << 1;
        den[k] <= den_in;
        rem[k] <= ge ? diff[qrs_pkg::DIV_DEN_W-1:0] : cur[qrs_pkg::DIV_DEN_W-1:0];
        quo[k] <= {q_in[qrs_pkg::DIV_NUM_W-2:0], ge};
        tag[k] <= t_in;
      end
    end
  end

  assign out_valid = valid[qrs_pkg::DIV_NUM_W-1];
  assign out_q     = quo[qrs_pkg::DIV_NUM_W-1];
  assign out_tag   = tag[qrs_pkg::DIV_NUM_W-1];

endmodule

@@ rtl/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c, Q12.12 in, Q20.12 out
// Pipeline: 4 front stages, 29 sqrt stages, 3 numerator stages, 43 divider
// stages and the output register. One coefficient set per cycle unless the pipe halts.
// The sqrt and both divider lanes resolve one bit per stage.
// Reset (rst, synchronous) empties the pipe and sets both tolerances to 1.
// ----------------------------------------------------------------------------
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver (
  input  logic               clk,
  input  logic               rst,
  qrs_coef_if.sink           coef,
  qrs_result_if.source       result,
  qrs_cfg_if.sink            cfg
);

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are always taken.
  // --------------------------------------------------------------------------
  logic [qrs_pkg::CTOL_W-1:0] coeff_tolerance;
  logic [qrs_pkg::DTOL_W-1:0] disc_tolerance;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_tolerance <= qrs_pkg::CTOL_W'(1);
      disc_tolerance  <= qrs_pkg::DTOL_W'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        qrs_pkg::REG_COEFF_TOL: coeff_tolerance <= cfg.data[qrs_pkg::CTOL_W-1:0];
        qrs_pkg::REG_DISC_TOL:  disc_tolerance  <= cfg.data[qrs_pkg::DTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance. Every stage moves together under en. The pipe only
  // halts when the output register holds an untaken beat and a finished
  // item sits in the last divider stage; bubbles at the tail keep flowing,
  // so new beats are taken while a result waits.
  // --------------------------------------------------------------------------
  logic en;
  logic rvalid;
  logic dv0, dv1;

  assign en         = !(rvalid && !result.ready && dv0);
  assign coef.ready = en;

  // --------------------------------------------------------------------------
  // Front end: magnitudes, products, discriminant, classification.
  // --------------------------------------------------------------------------
  logic                          fv;
  logic [qrs_pkg::SQ_IN_W-1:0]   fx;
  qrs_pkg::sq_side_t             fside;

  qrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (coef.valid),
    .coef_a    (coef.coef_a),
    .coef_b    (coef.coef_b),
    .coef_c    (coef.coef_c),
    .coeff_tol (coeff_tolerance),
    .disc_tol  (disc_tolerance),
    .out_valid (fv),
    .out_x     (fx),
    .out_side  (fside)
  );

  // --------------------------------------------------------------------------
  // sqrt(D * 4^G), truncated; only used for the two-root case.
  // --------------------------------------------------------------------------
  logic                          sv;
  logic [qrs_pkg::SQ_ROOT_W-1:0] sroot;
  qrs_pkg::sq_side_t             sside;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fv),
    .in_x      (fx),
    .in_side   (fside),
    .out_valid (sv),
    .out_root  (sroot),
    .out_side  (sside)
  );

  // --------------------------------------------------------------------------
  // P1: n1 = -b*2^G - s, n2 = -b*2^G + s
  // --------------------------------------------------------------------------
  logic [qrs_pkg::N_W-1:0]        pmag;
  logic signed [qrs_pkg::N_W-1:0] p, s;
  logic                           p1_valid;
  logic signed [qrs_pkg::N_W-1:0] p1_n1, p1_n2;
  qrs_pkg::sq_side_t              p1_side;

  always_comb begin
    pmag = qrs_pkg::N_W'(sside.bm) << qrs_pkg::GUARD_BITS;
    p    = sside.sb ? $signed(pmag) : -$signed(pmag);
    s    = $signed(qrs_pkg::N_W'(sroot));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= sv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_n1   <= p - s;
      p1_n2   <= p + s;
      p1_side <= sside;
    end
  end

  // --------------------------------------------------------------------------
  // P2: pick numerator, denominator and sign per status.
  //   linear: -c/b        double: -b/(2a)        two: n/(2a*2^G)
  // No-root and degenerate items divide 0 by 1.
  // --------------------------------------------------------------------------
  logic [qrs_pkg::NMAG_W-1:0]    mag1, mag2;
  logic [qrs_pkg::DIV_NUM_W-1:0] num1_n, num2_n;
  logic [qrs_pkg::DIV_DEN_W-1:0] den_n;
  logic                          neg1_n, neg2_n;
  logic                          p2_valid;
  logic [qrs_pkg::DIV_NUM_W-1:0] p2_num1, p2_num2;
  logic [qrs_pkg::DIV_DEN_W-1:0] p2_den;
  qrs_pkg::div_tag_t             p2_tag1, p2_tag2;

  always_comb begin
    mag1   = qrs_pkg::NMAG_W'(p1_n1[qrs_pkg::N_W-1] ? -p1_n1 : p1_n1);
    mag2   = qrs_pkg::NMAG_W'(p1_n2[qrs_pkg::N_W-1] ? -p1_n2 : p1_n2);
    num1_n = '0;
    num2_n = '0;
    den_n  = qrs_pkg::DIV_DEN_W'(1);
    neg1_n = 1'b0;
    neg2_n = 1'b0;
    case (p1_side.status)
      qrs_pkg::ST_LINEAR: begin
        num1_n = qrs_pkg::DIV_NUM_W'({p1_side.cm, {qrs_pkg::COEFF_FRAC_BITS{1'b0}}});
        num2_n = num1_n;
        den_n  = qrs_pkg::DIV_DEN_W'(p1_side.bm);
        neg1_n = (p1_side.sc == p1_side.sb);
        neg2_n = neg1_n;
      end
      qrs_pkg::ST_DOUBLE: begin
        num1_n = qrs_pkg::DIV_NUM_W'({p1_side.bm, {qrs_pkg::COEFF_FRAC_BITS{1'b0}}});
        num2_n = num1_n;
        den_n  = qrs_pkg::DIV_DEN_W'({p1_side.am, 1'b0});
        neg1_n = (p1_side.sb == p1_side.sa);
        neg2_n = neg1_n;
      end
      qrs_pkg::ST_TWO: begin
        num1_n = qrs_pkg::DIV_NUM_W'({mag1, {qrs_pkg::COEFF_FRAC_BITS{1'b0}}});
        num2_n = qrs_pkg::DIV_NUM_W'({mag2, {qrs_pkg::COEFF_FRAC_BITS{1'b0}}});
        den_n  = qrs_pkg::DIV_DEN_W'({p1_side.am, {(qrs_pkg::GUARD_BITS + 1){1'b0}}});
        neg1_n = (p1_n1[qrs_pkg::N_W-1] != p1_side.sa);
        neg2_n = (p1_n2[qrs_pkg::N_W-1] != p1_side.sa);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (en) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_num1        <= num1_n;
      p2_num2        <= num2_n;
      p2_den         <= den_n;
      p2_tag1.status <= p1_side.status;
      p2_tag1.neg    <= neg1_n;
      p2_tag2.status <= p1_side.status;
      p2_tag2.neg    <= neg2_n;
    end
  end

  // --------------------------------------------------------------------------
  // P3: add den/2 so the truncating divider rounds half away from zero.
  // --------------------------------------------------------------------------
  logic                          p3_valid;
  logic [qrs_pkg::DIV_NUM_W-1:0] p3_num1, p3_num2;
  logic [qrs_pkg::DIV_DEN_W-1:0] p3_den;
  qrs_pkg::div_tag_t             p3_tag1, p3_tag2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (en) begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_num1 <= p2_num1 + qrs_pkg::DIV_NUM_W'(p2_den >> 1);
      p3_num2 <= p2_num2 + qrs_pkg::DIV_NUM_W'(p2_den >> 1);
      p3_den  <= p2_den;
      p3_tag1 <= p2_tag1;
      p3_tag2 <= p2_tag2;
    end
  end

  // --------------------------------------------------------------------------
  // Two divider lanes, one per root.
  // --------------------------------------------------------------------------
  logic [qrs_pkg::DIV_NUM_W-1:0] dq0, dq1;
  qrs_pkg::div_tag_t             dtag0, dtag1;

  qrs_div u_div_first (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p3_valid),
    .in_num    (p3_num1),
    .in_den    (p3_den),
    .in_tag    (p3_tag1),
    .out_valid (dv0),
    .out_q     (dq0),
    .out_tag   (dtag0)
  );

  qrs_div u_div_second (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p3_valid),
    .in_num    (p3_num2),
    .in_den    (p3_den),
    .in_tag    (p3_tag2),
    .out_valid (dv1),
    .out_q     (dq1),
    .out_tag   (dtag1)
  );

  // --------------------------------------------------------------------------
  // Output: apply sign, clamp to ROOT_WIDTH, register the beat.
  // Returns {sat, value}.
  // --------------------------------------------------------------------------
  function automatic logic [qrs_pkg::ROOT_WIDTH:0] clamp_root(
    input logic                          neg,
    input logic [qrs_pkg::DIV_NUM_W-1:0] q
  );
    logic [qrs_pkg::ROOT_WIDTH:0] res;
    if (!neg) begin
      if (q >= qrs_pkg::ROOT_MAG_LIMIT) begin
        res = {1'b1, 1'b0, {(qrs_pkg::ROOT_WIDTH - 1){1'b1}}};
      end else begin
        res = {1'b0, q[qrs_pkg::ROOT_WIDTH-1:0]};
      end
    end else begin
      if (q > qrs_pkg::ROOT_MAG_LIMIT) begin
        res = {1'b1, 1'b1, {(qrs_pkg::ROOT_WIDTH - 1){1'b0}}};
      end else begin
        res = {1'b0, qrs_pkg::ROOT_WIDTH'(-q)};
      end
    end
    return res;
  endfunction

  logic [qrs_pkg::ROOT_WIDTH:0]  c0, c1;
  logic                          has_roots;
  logic [qrs_pkg::STATUS_W-1:0]  rstatus;
  logic [qrs_pkg::ROOT_WIDTH-1:0] rfirst, rsecond;
  logic                          rsat;

  always_comb begin
    c0        = clamp_root(dtag0.neg, dq0);
    c1        = clamp_root(dtag1.neg, dq1);
    has_roots = (dtag0.status == qrs_pkg::ST_LINEAR) || (dtag0.status == qrs_pkg::ST_DOUBLE) ||
                (dtag0.status == qrs_pkg::ST_TWO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (en && dv0) begin
      rvalid <= 1'b1;
    end else if (result.ready) begin
      rvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && dv0) begin
      rstatus <= dtag0.status;
      rfirst  <= has_roots ? c0[qrs_pkg::ROOT_WIDTH-1:0] : '0;
      rsecond <= has_roots ? c1[qrs_pkg::ROOT_WIDTH-1:0] : '0;
      rsat    <= has_roots && (c0[qrs_pkg::ROOT_WIDTH] || c1[qrs_pkg::ROOT_WIDTH]);
    end
  end

  assign result.valid       = rvalid;
  assign result.root_status = rstatus;
  assign result.first_root  = $signed(rfirst);
  assign result.second_root = $signed(rsecond);
  assign result.saturated   = rsat;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // both divider lanes carry the same item
  `QRS_ASSERT_IMPLIES(a_lanes_agree, clk, rst, dv0, dv1 && (dtag0.status == dtag1.status))
  // no-root and degenerate beats carry zero roots and no flag
  `QRS_ASSERT_IMPLIES(a_empty_roots_zero, clk, rst, result.valid && (result.root_status == qrs_pkg::ST_NONE || result.root_status == qrs_pkg::ST_DEGEN), result.first_root == '0 && result.second_root == '0 && !result.saturated)
  // a single root is reported twice
  `QRS_ASSERT_IMPLIES(a_single_root_pair, clk, rst, result.valid && (result.root_status == qrs_pkg::ST_LINEAR || result.root_status == qrs_pkg::ST_DOUBLE), result.first_root == result.second_root)
  // a halted pipe keeps its tail item
  `QRS_ASSERT_NEXT(a_stall_holds_tail, clk, rst, !en, $stable(dv0))

endmodule

@@ sim/quadratic_root_solver_tb.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Self-checking bench for the quadratic root solver. Coefficient sets go in
// on one channel and results come out on another, with random gaps on both
// sides. A built-in predictor works out status, roots and saturation from
// the coefficients and the tolerance registers, and every result beat is
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;

  typedef logic signed [qrs_pkg::COEFF_WIDTH-1:0] coef_t;
  typedef logic signed [qrs_pkg::ROOT_WIDTH-1:0]  root_t;

  typedef struct {
    logic [qrs_pkg::STATUS_W-1:0] status;
    root_t                        first;
    root_t                        second;
    logic                         sat;
  } roots_t;

  localparam int     DRAIN_CYCLES = 100;  // more than the pipeline latency
  localparam longint ROOT_LIM     = 64'sd1 <<< (qrs_pkg::ROOT_WIDTH - 1);
  localparam coef_t  COEF_MAX     = {1'b0, {(qrs_pkg::COEFF_WIDTH-1){1'b1}}};
  localparam coef_t  COEF_MIN     = {1'b1, {(qrs_pkg::COEFF_WIDTH-1){1'b0}}};
  localparam longint ONE          = 64'sd1 <<< qrs_pkg::COEFF_FRAC_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrs_coef_if   coef_ch ();
  qrs_result_if res_ch ();
  qrs_cfg_if    cfg_ch ();

  quadratic_root_solver uut (
    .clk    (clk),
    .rst    (rst),
    .coef   (coef_ch.sink),
    .result (res_ch.source),
    .cfg    (cfg_ch.sink)
  );

  always #10 clk = ~clk;

  // tolerance registers as the block should hold them
  longint unsigned coeff_tol = 1;
  longint unsigned disc_tol  = 1;

  roots_t expected_roots[$];
  int     err_count = 0;

  // idle control; idle_on is shared by sender and receiver
  bit idle_on   = 1'b1;
  int hold_left = 0;   // long receiver hold-off, in cycles
  int stall_left = 0;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint unsigned mag(longint x);
    return (x < 0) ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // rounded num/den, ties away from zero, sign applied, clamped to root range
  function automatic root_t rounded_root(bit neg, longint unsigned num,
                                         longint unsigned den, inout logic sat);
    longint unsigned q;
    q = (num + den / 2) / den;
    if (!neg) begin
      if (q > ROOT_LIM - 1) begin
        q = ROOT_LIM - 1;
        sat = 1'b1;
      end
      return root_t'(q);
    end
    if (q > ROOT_LIM) begin
      q = ROOT_LIM;
      sat = 1'b1;
    end
    return root_t'(-longint'(q));
  endfunction

  function automatic roots_t solve_roots(coef_t ca, coef_t cb, coef_t cc);
    roots_t r;
    longint a, b, c, p, n1, n2;
    longint unsigned am, bm, cm, bb, ac4, d, s, den;
    bit d_neg;
    a = ca; b = cb; c = cc;
    am = mag(a); bm = mag(b); cm = mag(c);
    r.first = '0; r.second = '0; r.sat = 1'b0;
    if (am == 0 || am < coeff_tol) begin
      if (bm == 0 || bm < coeff_tol) begin
        r.status = qrs_pkg::ST_DEGEN;
      end else begin
        r.status = qrs_pkg::ST_LINEAR;
        r.first  = rounded_root((c < 0) == (b < 0), cm << qrs_pkg::COEFF_FRAC_BITS,
                                bm, r.sat);
        r.second = r.first;
      end
    end else begin
      bb = bm * bm;
      ac4 = 4 * am * cm;
      d_neg = 1'b0;
      d = 0;
      if (((a < 0) != (c < 0)) || cm == 0) d = bb + ac4;
      else if (bb >= ac4) d = bb - ac4;
      else d_neg = 1'b1;
      if (d_neg) begin
        r.status = qrs_pkg::ST_NONE;
      end else if (d < disc_tol) begin
        r.status = qrs_pkg::ST_DOUBLE;
        r.first  = rounded_root((b < 0) == (a < 0), bm << qrs_pkg::COEFF_FRAC_BITS,
                                2 * am, r.sat);
        r.second = r.first;
      end else begin
        s   = int_sqrt(d << (2 * qrs_pkg::GUARD_BITS));
        p   = -b * (64'sd1 <<< qrs_pkg::GUARD_BITS);
        n1  = p - longint'(s);
        n2  = p + longint'(s);
        den = (2 * am) << qrs_pkg::GUARD_BITS;
        r.status = qrs_pkg::ST_TWO;
        r.first  = rounded_root((n1 < 0) != (a < 0), mag(n1) << qrs_pkg::COEFF_FRAC_BITS,
                                den, r.sat);
        r.second = rounded_root((n2 < 0) != (a < 0), mag(n2) << qrs_pkg::COEFF_FRAC_BITS,
                                den, r.sat);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result sink: random stalls plus an optional long hold-off; checks each beat
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    roots_t exp_r;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_roots.size() == 0) begin
          $error("result beat with nothing expected");
          err_count++;
        end else begin
          exp_r = expected_roots.pop_front();
          if (res_ch.root_status !== exp_r.status) begin
            $error("root_status: expected %0d, got %0d", exp_r.status, res_ch.root_status);
            err_count++;
          end
          if (res_ch.first_root !== exp_r.first) begin
            $error("first_root: expected %0d, got %0d", exp_r.first, res_ch.first_root);
            err_count++;
          end
          if (res_ch.second_root !== exp_r.second) begin
            $error("second_root: expected %0d, got %0d", exp_r.second, res_ch.second_root);
            err_count++;
          end
          if (res_ch.saturated !== exp_r.sat) begin
            $error("saturated: expected %0d, got %0d", exp_r.sat, res_ch.saturated);
            err_count++;
          end
        end
        stall_left = idle_on ? $urandom_range(0, 18) : 0;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      if (hold_left > 0) hold_left--;
      res_ch.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  // --------------------------------------------------------------------------
  // Sender side. valid stays high after a beat; it drops only before a gap or a
  // drain, so it is never lowered and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_coefs(coef_t a, coef_t b, coef_t c);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      coef_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coef_ch.valid  <= 1'b1;
    coef_ch.coef_a <= a;
    coef_ch.coef_b <= b;
    coef_ch.coef_c <= c;
    do @(posedge clk); while (!coef_ch.ready);
    expected_roots.push_back(solve_roots(a, b, c));
  endtask

  // called right at the edge of the last accepted beat
  task automatic drain_results();
    coef_ch.valid <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // leaves valid high; set_tolerances drops it after the last write
  task automatic write_reg(logic [qrs_pkg::CFG_IDX_W-1:0] idx,
                           logic [qrs_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == qrs_pkg::REG_COEFF_TOL) coeff_tol = data & 32'h7F_FFFF;
    else                               disc_tol  = data;
  endtask

  task automatic set_tolerances(logic [qrs_pkg::CFG_DATA_W-1:0] ctol,
                                logic [qrs_pkg::CFG_DATA_W-1:0] dtol);
    write_reg(qrs_pkg::REG_COEFF_TOL, ctol);
    write_reg(qrs_pkg::REG_DISC_TOL, dtol);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random coefficient: full range, small values, extremes, or near the tolerance
  function automatic coef_t rand_coef();
    case ($urandom_range(0, 5))
      0, 1: return coef_t'($urandom);
      2:    return coef_t'($signed($urandom_range(0, 16 * ONE)) - 8 * ONE);
      3: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          3: return coef_t'(1);
          default: return coef_t'(-1);
        endcase
      end
      4:    return coef_t'($signed($urandom_range(0, 2 * coeff_tol + 2)) - longint'(coeff_tol) - 1);
      default: return coef_t'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  // a*(x-r1)*(x-r2) with small integer-ish roots: hits two-root and double-root paths
  task automatic send_factored();
    longint k, r1, r2;
    k  = $signed($urandom_range(1, 4 * ONE)) * ($urandom_range(0, 1) ? 1 : -1);
    r1 = $signed($urandom_range(0, 16)) - 8;
    r2 = $urandom_range(0, 3) == 0 ? r1 : $signed($urandom_range(0, 16)) - 8;
    if (mag(k * (r1 + r2)) >= (64'd1 << 23) || mag(k * r1 * r2) >= (64'd1 << 23))
      k = k / 16 + 1;
    send_coefs(coef_t'(k), coef_t'(-k * (r1 + r2)), coef_t'(k * r1 * r2));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    send_coefs('0, '0, coef_t'(ONE));                       // degenerate
    send_coefs('0, coef_t'(2 * ONE), coef_t'(-4 * ONE));    // linear, root 2
    send_coefs('0, coef_t'(-3 * ONE), coef_t'(ONE));        // linear, negative b
    send_coefs('0, coef_t'(1), COEF_MAX);                   // linear, clamps low
    send_coefs('0, coef_t'(1), COEF_MIN);                   // linear, clamps high
    send_coefs(coef_t'(ONE), '0, coef_t'(ONE));             // no real roots
    send_coefs(coef_t'(ONE), coef_t'(2 * ONE), coef_t'(ONE)); // double root
    send_coefs(coef_t'(ONE), '0, coef_t'(-4 * ONE));        // two roots +-2
    send_coefs(coef_t'(-ONE), coef_t'(3 * ONE), '0);        // c zero
    send_coefs(COEF_MAX, COEF_MAX, COEF_MAX);
    send_coefs(COEF_MIN, COEF_MIN, COEF_MIN);
    send_coefs(COEF_MIN, COEF_MAX, COEF_MAX);
    send_coefs(COEF_MAX, COEF_MIN, COEF_MIN);
    send_coefs(coef_t'(1), COEF_MAX, coef_t'(1));           // tiny a, one huge root
    send_coefs(coef_t'(1), COEF_MIN, COEF_MAX);
    send_coefs(coef_t'(-1), '0, COEF_MIN);
    send_coefs(coef_t'(1), coef_t'(1), '0);
    drain_results();
    // tolerance extremes: near-zero D widened, then D zero giving two equal roots
    set_tolerances(32'h7F_FFFF, 32'hFFFF_FFFF);
    send_coefs(coef_t'(ONE), coef_t'(3 * ONE), coef_t'(2 * ONE));
    send_coefs(COEF_MAX, coef_t'(ONE), coef_t'(ONE));       // a at tolerance, not below
    send_coefs(COEF_MAX, COEF_MAX, '0);
    drain_results();
    set_tolerances(32'd0, 32'd0);
    send_coefs(coef_t'(ONE), coef_t'(2 * ONE), coef_t'(ONE));
    send_coefs('0, '0, '0);
    send_coefs('0, coef_t'(1), coef_t'(1));
    drain_results();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 5) send_factored();
      else send_coefs(rand_coef(), rand_coef(), rand_coef());
    end
    idle_on = 1'b1;
    drain_results();
  endtask

  task automatic test_backpressure();
    idle_on   = 1'b0;
    hold_left = 400;   // receiver blocks long enough to fill the pipe
    for (int i = 0; i < 200; i++) send_factored();
    idle_on = 1'b1;
    drain_results();
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_factored();
    drain_results();   // sender waits for every result before carrying on
    for (int i = 0; i < 20; i++) send_coefs(rand_coef(), rand_coef(), rand_coef());
    drain_results();
  endtask

  initial begin
    coef_ch.valid  <= 1'b0;
    coef_ch.coef_a <= '0;
    coef_ch.coef_b <= '0;
    coef_ch.coef_c <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    set_tolerances(32'd1, 32'd1);
    test_random(180);
    set_tolerances(32'd0, 32'hFFFF_FFFF);
    test_random(120);
    set_tolerances(32'h7F_FFFF, 32'd0);
    test_random(80);
    set_tolerances($urandom, $urandom);
    test_random(120);
    set_tolerances($urandom_range(0, 64), $urandom_range(0, 1 << 24));
    test_random(180);
    test_backpressure();
    test_drain_pause();

    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // watchdog
  initial begin
    #(20 * 3_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
